@@ rtl/mpbc_pkg.sv @@
// ----------------------------------------------------------------------------
// mpbc_pkg: shared types and constants for the multi-press button counter
// Field widths, reset values, register indexes and the config bundle
// ----------------------------------------------------------------------------
package mpbc_pkg;

  localparam int NUM_BUTTONS_DEF = 4;
  localparam int EDGE_W          = 4;
  localparam int OUT_FIELDS      = 4;
  localparam int COUNT_W         = 4;
  localparam int QUIET_W         = 11;
  localparam int DEBOUNCE_W      = 10;
  localparam int TIMEOUT_W       = 11;
  localparam int CFG_DATA_W      = 11;
  localparam int CFG_INDEX_W     = 2;

  localparam logic [QUIET_W-1:0]    QUIET_MAX      = '1;
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 10'd150;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 11'd500;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TIMEOUT  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce;
    logic [TIMEOUT_W-1:0]  timeout;
  } cfg_t;

endpackage

@@ rtl/mpbc_chan_if.sv @@
// ----------------------------------------------------------------------------
// mpbc_chan_if: valid/ready channels of the multi-press button counter
// Tick channel carries the edge mask, result channel the four press counts
// ----------------------------------------------------------------------------
interface mpbc_in_if;
  logic                        valid;
  logic                        ready;
  logic [mpbc_pkg::EDGE_W-1:0] edge_mask;

  modport source (output valid, output edge_mask, input ready);
  modport sink   (input valid, input edge_mask, output ready);
endinterface

interface mpbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [mpbc_pkg::COUNT_W-1:0] presses_0;
  logic [mpbc_pkg::COUNT_W-1:0] presses_1;
  logic [mpbc_pkg::COUNT_W-1:0] presses_2;
  logic [mpbc_pkg::COUNT_W-1:0] presses_3;

  modport source (output valid, output presses_0, output presses_1,
                  output presses_2, output presses_3, input ready);
  modport sink   (input valid, input presses_0, input presses_1,
                  input presses_2, input presses_3, output ready);
endinterface

@@ rtl/mpbc_button.sv @@
// ----------------------------------------------------------------------------
// mpbc_button: per-button quiet timer and press counter
// Updates its state on each tick that advances and reports a finished burst
// ----------------------------------------------------------------------------
module mpbc_button (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          edge_in,
  input  mpbc_pkg::cfg_t                cfg,
  output logic [mpbc_pkg::COUNT_W-1:0]  report
);

  logic [mpbc_pkg::QUIET_W-1:0] quiet_r;
  logic [mpbc_pkg::QUIET_W-1:0] quiet_nxt;
  logic [mpbc_pkg::QUIET_W-1:0] quiet_inc;
  logic [mpbc_pkg::COUNT_W-1:0] pending_r;
  logic [mpbc_pkg::COUNT_W-1:0] pending_nxt;
  logic [mpbc_pkg::COUNT_W-1:0] pending_add;
  logic                         counted;
  logic                         fire;

  always_comb begin
    quiet_inc = (quiet_r == mpbc_pkg::QUIET_MAX) ? quiet_r
                                                 : quiet_r + 1'b1;
    // edge counts only after the debounce window and below saturation
    counted = edge_in
           && (quiet_inc > {1'b0, cfg.debounce})
           && (pending_r != mpbc_pkg::COUNT_MAX);
    pending_add = counted ? pending_r + 1'b1 : pending_r;
    quiet_nxt   = edge_in ? '0 : quiet_inc;
    fire        = (pending_add != '0) && (quiet_nxt > cfg.timeout);
    report      = fire ? pending_add : '0;
    pending_nxt = fire ? '0 : pending_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quiet_r   <= mpbc_pkg::QUIET_MAX;
      pending_r <= '0;
    end else if (advance) begin
      quiet_r   <= quiet_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

@@ rtl/multi_press_button_counter_unit.sv @@
// ----------------------------------------------------------------------------
// multi_press_button_counter_unit: multi-click detector over NUM_BUTTONS keys
// Path: a tick request accepted into the input register, then lane update into
// the result register. Throughput: one tick per cycle while the result side is
// not stalled; the per-button compare and counter update are combinational.
// Sync reset: quiet timers saturated, counts zero, debounce 150, timeout 500.
// ----------------------------------------------------------------------------
module multi_press_button_counter_unit #(
  parameter int NUM_BUTTONS = mpbc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mpbc_in_if.sink                          in_chan,
  mpbc_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [mpbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpbc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mpbc_pkg::cfg_t cfg_r;

  logic                         s1_valid_r;
  logic [mpbc_pkg::EDGE_W-1:0]  s1_mask_r;
  logic                         out_valid_r;
  logic [mpbc_pkg::COUNT_W-1:0] out_presses_r [mpbc_pkg::OUT_FIELDS];
  logic [mpbc_pkg::COUNT_W-1:0] lane_report [NUM_BUTTONS];
  logic [mpbc_pkg::COUNT_W-1:0] field_report [mpbc_pkg::OUT_FIELDS];
  logic                         s1_advance;

  // stage 1 moves on when the result register is empty or being drained
  assign s1_advance    = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce <= mpbc_pkg::DEBOUNCE_RESET;
      cfg_r.timeout  <= mpbc_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mpbc_pkg::REG_DEBOUNCE: cfg_r.debounce <= cfg_wdata[mpbc_pkg::DEBOUNCE_W-1:0];
        mpbc_pkg::REG_TIMEOUT:  cfg_r.timeout  <= cfg_wdata[mpbc_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_mask_r <= in_chan.edge_mask;
    end
  end

  genvar b;
  generate
    for (b = 0; b < NUM_BUTTONS; b++) begin : g_lane
      logic lane_edge;
      // only the first four buttons have an edge bit
      if (b < mpbc_pkg::EDGE_W) begin : g_edge
        assign lane_edge = s1_mask_r[b];
      end else begin : g_no_edge
        assign lane_edge = 1'b0;
      end

      mpbc_button u_button (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_advance),
        .edge_in (lane_edge),
        .cfg     (cfg_r),
        .report  (lane_report[b])
      );
    end

    for (b = 0; b < mpbc_pkg::OUT_FIELDS; b++) begin : g_field
      if (b < NUM_BUTTONS) begin : g_used
        assign field_report[b] = lane_report[b];
      end else begin : g_unused
        assign field_report[b] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_presses_r <= field_report;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.presses_0 = out_presses_r[0];
  assign out_chan.presses_1 = out_presses_r[1];
  assign out_chan.presses_2 = out_presses_r[2];
  assign out_chan.presses_3 = out_presses_r[3];

endmodule

@@ rtl/mpbc_checker.sv @@
// ----------------------------------------------------------------------------
// mpbc_checker: port-level checks for the multi-press button counter
// Watches the tick and result channels; bound to the top level below
// ----------------------------------------------------------------------------
module mpbc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [mpbc_pkg::COUNT_W-1:0] presses_0,
  input logic [mpbc_pkg::COUNT_W-1:0] presses_1,
  input logic [mpbc_pkg::COUNT_W-1:0] presses_2,
  input logic [mpbc_pkg::COUNT_W-1:0] presses_3
);

  // no result may linger through reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an accepted tick always leaves a result waiting once past the input register
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("accepted tick produced no result");

  // a draining result side never blocks new tick requests
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("tick request blocked while results drain");

  // stalled result holds its counts
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(presses_0) && $stable(presses_1)
       && $stable(presses_2) && $stable(presses_3)))
    else $error("stalled result changed");

endmodule

bind multi_press_button_counter_unit mpbc_checker u_mpbc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .presses_0 (out_chan.presses_0),
  .presses_1 (out_chan.presses_1),
  .presses_2 (out_chan.presses_2),
  .presses_3 (out_chan.presses_3)
);
